FILE: sv/ifr_pkg.sv
`timescale 1ns / 1ps
package ifr_pkg;

  localparam int StoreDepth = 29;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int PosW       = 9;
  localparam int IdxW       = 4;
  localparam int ValW       = 32;
  localparam int TdataW     = 56;
  localparam int CfgAddrW   = 2;

  localparam logic [AddrW-1:0] LastSumAddr  = AddrW'(26);
  localparam logic [AddrW-1:0] SumAddr      = AddrW'(28);
  localparam logic [AddrW-1:0] PresAddr     = AddrW'(24);

  localparam logic [7:0] FirstSyncReset  = 8'h88;
  localparam logic [7:0] SecondSyncReset = 8'hAF;
  localparam logic [7:0] SumSeedReset    = 8'h53;

  localparam logic [CfgAddrW-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_SECOND_SYNC = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_SUM_SEED    = 2'd2;

  typedef enum logic [3:0] {
    PH_HUNT1 = 4'b0001,
    PH_HUNT2 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {PTR_HOLD = 2'd0, PTR_CLR = 2'd1, PTR_INC = 2'd2} ptr_op_t;
  typedef enum logic [1:0] {ACC_NONE = 2'd0, ACC_SEED = 2'd1, ACC_ADD = 2'd2} acc_op_t;
  typedef enum logic [1:0] {SHF_NONE = 2'd0, SHF_HI = 2'd1, SHF_LO = 2'd2} shf_op_t;
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0, EMIT_F16 = 2'd1, EMIT_F32 = 2'd2, EMIT_ERR = 2'd3
  } emit_op_t;
  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0, JMP_PTR_NE = 2'd1, JMP_SUM_NE = 2'd2, JMP_DONE = 2'd3
  } jmp_t;

  typedef logic [3:0] step_t;

  localparam step_t StepStart  = 4'd0;
  localparam step_t StepSum    = 4'd1;
  localparam step_t StepWait   = 4'd2;
  localparam step_t StepRsum   = 4'd3;
  localparam step_t StepCheck  = 4'd4;
  localparam step_t StepHi     = 4'd5;
  localparam step_t StepLo     = 4'd6;
  localparam step_t StepEmit16 = 4'd7;
  localparam step_t StepPres   = 4'd8;
  localparam step_t StepEmit32 = 4'd9;
  localparam step_t StepErr    = 4'd10;

  typedef struct packed {
    ptr_op_t          ptr_op;
    acc_op_t          acc_op;
    shf_op_t          shf_op;
    logic             rsum_ld;
    logic             fidx_clr;
    emit_op_t         emit_op;
    jmp_t             jmp;
    logic [AddrW-1:0] lim;
    step_t            target;
  } uword_t;

  typedef struct packed {
    logic [AddrW-1:0] ptr;
    logic             sum_ne;
    logic             out_busy;
  } flags_t;

  // The store read is registered, so each step acts on the byte addressed by the
  // previous step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      StepStart: begin
        w.ptr_op = PTR_INC;
        w.acc_op = ACC_SEED;
      end
      StepSum: begin
        w.ptr_op = PTR_INC;
        w.acc_op = ACC_ADD;
        w.jmp    = JMP_PTR_NE;
        w.lim    = LastSumAddr + AddrW'(1);
        w.target = StepSum;
      end
      StepWait: begin
        w.ptr_op = PTR_HOLD;
      end
      StepRsum: begin
        w.ptr_op   = PTR_CLR;
        w.rsum_ld  = 1'b1;
        w.fidx_clr = 1'b1;
      end
      StepCheck: begin
        w.ptr_op = PTR_INC;
        w.jmp    = JMP_SUM_NE;
        w.target = StepErr;
      end
      StepHi: begin
        w.ptr_op = PTR_INC;
        w.shf_op = SHF_HI;
      end
      StepLo: begin
        w.shf_op = SHF_HI;
      end
      StepEmit16: begin
        w.ptr_op  = PTR_INC;
        w.emit_op = EMIT_F16;
        w.jmp     = JMP_PTR_NE;
        w.lim     = PresAddr;
        w.target  = StepHi;
      end
      StepPres: begin
        w.ptr_op = PTR_INC;
        w.shf_op = SHF_LO;
        w.jmp    = JMP_PTR_NE;
        w.lim    = SumAddr;
        w.target = StepPres;
      end
      StepEmit32: begin
        w.emit_op = EMIT_F32;
        w.jmp     = JMP_DONE;
      end
      StepErr: begin
        w.emit_op = EMIT_ERR;
        w.jmp     = JMP_DONE;
      end
      default: begin
        w.jmp = JMP_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/ifr_ram.sv
`timescale 1ns / 1ps
module ifr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 29
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ifr_frontend.sv
`timescale 1ns / 1ps
module ifr_frontend (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     rx_byte,
  input  logic [7:0]                     first_sync,
  input  logic [7:0]                     second_sync,
  output logic                           start,
  output logic                           wr_en,
  output logic [ifr_pkg::AddrW-1:0]      wr_addr,
  output logic [ifr_pkg::StoreDepth-1:0] vld
);

  ifr_pkg::phase_t             phase;
  ifr_pkg::phase_t             phase_next;
  logic [7:0]                  frame_length;
  logic [ifr_pkg::PosW-1:0]    byte_position;
  logic                        at_end;

  assign at_end  = byte_position == ({1'b0, frame_length} + 9'd1);
  assign start   = accept && (phase == ifr_pkg::PH_DATA) && at_end;
  assign wr_en   = accept && (phase == ifr_pkg::PH_DATA) && !at_end &&
                   (byte_position < ifr_pkg::PosW'(ifr_pkg::StoreDepth));
  assign wr_addr = byte_position[ifr_pkg::AddrW-1:0];

  always_comb begin
    phase_next = phase;
    unique case (phase)
      ifr_pkg::PH_HUNT1: if (rx_byte == first_sync) phase_next = ifr_pkg::PH_HUNT2;
      ifr_pkg::PH_HUNT2: if (rx_byte == second_sync) phase_next = ifr_pkg::PH_LEN;
      ifr_pkg::PH_LEN:   phase_next = ifr_pkg::PH_DATA;
      ifr_pkg::PH_DATA:  if (at_end) phase_next = ifr_pkg::PH_HUNT1;
      default:           phase_next = ifr_pkg::PH_HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ifr_pkg::PH_HUNT1;
      frame_length  <= '0;
      byte_position <= '0;
      vld           <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == ifr_pkg::PH_LEN) begin
        frame_length  <= rx_byte;
        byte_position <= '0;
      end else if (phase == ifr_pkg::PH_DATA && !at_end) begin
        byte_position <= byte_position + 9'd1;
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/ifr_sequencer.sv
`timescale 1ns / 1ps
module ifr_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ifr_pkg::flags_t flags,
  output ifr_pkg::uword_t uw,
  output logic            en,
  output logic            run
);

  ifr_pkg::step_t step;
  ifr_pkg::step_t step_inc;
  logic           hold;

  assign uw       = ifr_pkg::ucode(step);
  assign hold     = (uw.emit_op != ifr_pkg::EMIT_NONE) && flags.out_busy;
  assign en       = run && !hold;
  assign step_inc = step + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ifr_pkg::StepStart;
      run  <= 1'b0;
    end else if (start) begin
      step <= ifr_pkg::StepStart;
      run  <= 1'b1;
    end else if (en) begin
      unique case (uw.jmp)
        ifr_pkg::JMP_NEXT:   step <= step_inc;
        ifr_pkg::JMP_PTR_NE: step <= (flags.ptr != uw.lim) ? uw.target : step_inc;
        ifr_pkg::JMP_SUM_NE: step <= flags.sum_ne ? uw.target : step_inc;
        ifr_pkg::JMP_DONE:   run  <= 1'b0;
        default:             run  <= 1'b0;
      endcase
    end
  end

endmodule

FILE: sv/ifr_datapath.sv
`timescale 1ns / 1ps
module ifr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           en,
  input  ifr_pkg::uword_t                uw,
  input  logic [7:0]                     rdata,
  input  logic [ifr_pkg::StoreDepth-1:0] vld,
  input  logic [7:0]                     sum_seed,
  input  logic                           m_tready,
  output ifr_pkg::flags_t                flags,
  output logic                           m_tvalid,
  output logic [ifr_pkg::TdataW-1:0]     m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);

  logic [ifr_pkg::AddrW-1:0] ptr;
  logic                      rvld;
  logic [7:0]                data;
  logic [7:0]                acc;
  logic [7:0]                rsum;
  logic [ifr_pkg::ValW-1:0]  shreg;
  logic [ifr_pkg::IdxW-1:0]  fidx;
  logic [ifr_pkg::ValW-1:0]  value;

  assign data           = rvld ? rdata : 8'd0;
  assign flags.ptr      = ptr;
  assign flags.sum_ne   = acc != rsum;
  assign flags.out_busy = m_tvalid && !m_tready;

  always_comb begin
    unique case (uw.emit_op)
      ifr_pkg::EMIT_F16: value = {{16{shreg[15]}}, shreg[15:0]};
      ifr_pkg::EMIT_F32: value = shreg;
      default:           value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rvld <= vld[ptr];
    if (rst) begin
      ptr      <= '0;
      fidx     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (en && (uw.emit_op != ifr_pkg::EMIT_NONE)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (start) begin
        ptr <= '0;
      end else if (en) begin
        case (uw.ptr_op)
          ifr_pkg::PTR_CLR: ptr <= '0;
          ifr_pkg::PTR_INC: ptr <= ptr + 5'd1;
          default:          ptr <= ptr;
        endcase
        case (uw.acc_op)
          ifr_pkg::ACC_SEED: acc <= sum_seed;
          ifr_pkg::ACC_ADD:  acc <= acc + data;
          default:           acc <= acc;
        endcase
        case (uw.shf_op)
          ifr_pkg::SHF_HI: shreg <= {shreg[23:0], data};
          ifr_pkg::SHF_LO: shreg <= {data, shreg[31:8]};
          default:         shreg <= shreg;
        endcase
        if (uw.rsum_ld) begin
          rsum <= data;
        end
        if (uw.fidx_clr) begin
          fidx <= '0;
        end else if (uw.emit_op == ifr_pkg::EMIT_F16 || uw.emit_op == ifr_pkg::EMIT_F32) begin
          fidx <= fidx + 4'd1;
        end
        if (uw.emit_op != ifr_pkg::EMIT_NONE) begin
          m_tuser  <= uw.emit_op == ifr_pkg::EMIT_ERR;
          m_tlast  <= uw.emit_op != ifr_pkg::EMIT_F16;
          m_tdata  <= {4'd0, rsum, acc, value,
                       (uw.emit_op == ifr_pkg::EMIT_ERR) ? 4'd0 : fidx};
        end
      end
    end
  end

endmodule

FILE: sv/imu_frame_receiver.sv
`timescale 1ns / 1ps
// Byte-serial frame receiver for an inertial sensor.
// Bytes arrive on the s_ stream, one per transaction. The block hunts for
// two sync bytes, takes a length byte L and stores payload positions 0 to 28
// of the following L+1 bytes. The byte after the payload starts the check.
// Results leave on the m_ stream; a frame yields 13 decoded fields or one
// mismatch result, and the final one carries tlast.
// Bytes that do not end a frame never hold s_tready low. At a frame end a
// microcoded sequencer walks the single read port of the payload store,
// one byte a cycle for the sum and a high, a low and an emit step for
// each 16-bit field. During that time s_tready is low. Results pass
// through one output register, so a stalled receiver holds the sequencer
// at its next emit step only.
// Reset restores the sync and seed registers, clears the parser state and
// marks every store entry as zero. Configuration writes are taken at any
// edge with cfg_we high and should be made while the block is idle.
module imu_frame_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ifr_pkg::CfgAddrW-1:0]        cfg_addr,
  input  logic [7:0]                          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // rx_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // field_index, field_value, computed_sum, received_sum, zero pad
  output logic [ifr_pkg::TdataW-1:0]          m_tdata,
  output logic                                m_tuser,   // kind
  output logic                                m_tlast
);

  logic [7:0]                     first_sync;
  logic [7:0]                     second_sync;
  logic [7:0]                     sum_seed;
  logic                           accept;
  logic                           start;
  logic                           wr_en;
  logic [ifr_pkg::AddrW-1:0]      wr_addr;
  logic [ifr_pkg::StoreDepth-1:0] vld;
  logic [7:0]                     rdata;
  logic                           en;
  logic                           run;
  ifr_pkg::uword_t                uw;
  ifr_pkg::flags_t                flags;

  assign s_tready = !run;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= ifr_pkg::FirstSyncReset;
      second_sync <= ifr_pkg::SecondSyncReset;
      sum_seed    <= ifr_pkg::SumSeedReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        ifr_pkg::CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        ifr_pkg::CFG_SECOND_SYNC: second_sync <= cfg_data;
        ifr_pkg::CFG_SUM_SEED:    sum_seed    <= cfg_data;
        default: ;
      endcase
    end
  end

  ifr_frontend u_frontend (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .first_sync  (first_sync),
    .second_sync (second_sync),
    .start       (start),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .vld         (vld)
  );

  ifr_ram #(
    .WIDTH (8),
    .DEPTH (ifr_pkg::StoreDepth)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (s_tdata),
    .raddr (flags.ptr),
    .rdata (rdata)
  );

  ifr_sequencer u_sequencer (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .uw    (uw),
    .en    (en),
    .run   (run)
  );

  ifr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .en       (en),
    .uw       (uw),
    .rdata    (rdata),
    .vld      (vld),
    .sum_seed (sum_seed),
    .m_tready (m_tready),
    .flags    (flags),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_err_single : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata[35:0] == 36'd0))
    else $error("mismatch result is not a lone zero result");

  a_last_is_pressure : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tlast |-> m_tdata[3:0] == 4'd12)
    else $error("decoded frame ends on a field other than pressure");

  a_match_sums : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[43:36] == m_tdata[51:44])
    else $error("decoded field sent with differing checksums");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    start |=> run && !s_tready)
    else $error("sequencer did not take the frame end");

endmodule

FILE: test/tb_imu_frame_receiver.sv
`timescale 1ns / 1ps
module tb_imu_frame_receiver;

  localparam int QuietLimit = 4000;

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [7:0]  csum;
    logic [7:0]  rsum;
    logic        last;
  } imu_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [ifr_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [7:0]                   cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [ifr_pkg::TdataW-1:0]   m_tdata;
  logic                         m_tuser;
  logic                         m_tlast;

  imu_frame_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  logic [7:0]  sync_first  = ifr_pkg::FirstSyncReset;
  logic [7:0]  sync_second = ifr_pkg::SecondSyncReset;
  logic [7:0]  seed_value  = ifr_pkg::SumSeedReset;

  logic [7:0]  rx_queue[$];
  imu_result_t awaited_fields[$];
  bit          steady = 1'b0;
  bit          byte_taken = 1'b0;
  int          fault_count = 0;
  int          quiet_cycles = 0;
  int          bytes_queued = 0;

  ifr_pkg::phase_t rx_phase = ifr_pkg::PH_HUNT1;
  logic [7:0]  rx_len = '0;
  logic [8:0]  rx_pos = '0;
  logic [7:0]  rx_store [ifr_pkg::StoreDepth];
  logic [7:0]  gen_store [ifr_pkg::StoreDepth];

  // Frame parser and decoder; queues the fields that each frame end produces.
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0]  sum;
    imu_result_t r;
    case (rx_phase)
      ifr_pkg::PH_HUNT1: begin
        if (b == sync_first) rx_phase = ifr_pkg::PH_HUNT2;
      end
      ifr_pkg::PH_HUNT2: begin
        if (b == sync_second) rx_phase = ifr_pkg::PH_LEN;
      end
      ifr_pkg::PH_LEN: begin
        rx_len   = b;
        rx_pos   = '0;
        rx_phase = ifr_pkg::PH_DATA;
      end
      default: begin
        if (rx_pos == {1'b0, rx_len} + 9'd1) begin
          rx_phase = ifr_pkg::PH_HUNT1;
          sum = seed_value;
          for (int k = 0; k < 27; k++) sum = sum + rx_store[k];
          r.csum = sum;
          r.rsum = rx_store[28];
          if (sum == rx_store[28]) begin
            for (int k = 0; k < 13; k++) begin
              r.kind = 1'b0;
              r.idx  = 4'(k);
              if (k < 12) begin
                r.val = {{16{rx_store[2*k][7]}}, rx_store[2*k], rx_store[2*k+1]};
              end else begin
                r.val = {rx_store[27], rx_store[26], rx_store[25], rx_store[24]};
              end
              r.last = (k == 12);
              awaited_fields.push_back(r);
            end
          end else begin
            r.kind = 1'b1;
            r.idx  = '0;
            r.val  = '0;
            r.last = 1'b1;
            awaited_fields.push_back(r);
          end
        end else begin
          if (rx_pos < 9'(ifr_pkg::StoreDepth)) rx_store[rx_pos] = b;
          rx_pos = rx_pos + 9'd1;
        end
      end
    endcase
  endtask

  task automatic check_field_output();
    imu_result_t got;
    imu_result_t want;
    got.kind = m_tuser;
    got.idx  = m_tdata[3:0];
    got.val  = m_tdata[35:4];
    got.csum = m_tdata[43:36];
    got.rsum = m_tdata[51:44];
    got.last = m_tlast;
    if (awaited_fields.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: result with nothing awaited: kind=%0d idx=%0d val=%h",
                 $time, got.kind, got.idx, got.val,
                 " sum=%h/%h last=%0d", got.csum, got.rsum, got.last);
    end else begin
      want = awaited_fields.pop_front();
      if (got.kind !== want.kind || got.idx !== want.idx || got.val !== want.val ||
          got.csum !== want.csum || got.rsum !== want.rsum || got.last !== want.last) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("%0t: expected kind=%0d idx=%0d val=%h sum=%h/%h last=%0d",
                   $time, want.kind, want.idx, want.val, want.csum, want.rsum,
                   want.last);
          $display("%0t:      got kind=%0d idx=%0d val=%h sum=%h/%h last=%0d",
                   $time, got.kind, got.idx, got.val, got.csum, got.rsum, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = s_tvalid && s_tready;
      if (m_tvalid && m_tready) check_field_output();
      if (byte_taken) parse_rx_byte(s_tdata);
      if (byte_taken || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_imu_frame_receiver: errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      if (rx_queue.size() > 0 && (steady || $urandom_range(99) >= 14)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= rx_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(99) >= 14);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_other(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b);
    return v;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_queue.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) push_byte(pick_other(sync_first, sync_second));
  endtask

  // Builds one frame. A good frame gets a matching checksum, taking into account
  // the stale store bytes that a short frame leaves in place.
  task automatic push_frame(input int len, input bit good, input bit stray);
    logic [7:0] body [256];
    logic [7:0] img [ifr_pkg::StoreDepth];
    logic [7:0] sum;
    img = gen_store;
    for (int p = 0; p <= len; p++) begin
      body[p] = pick_byte();
      if (p < ifr_pkg::StoreDepth) img[p] = body[p];
    end
    if (good) begin
      sum = seed_value;
      for (int k = 0; k < 27; k++) sum = sum + img[k];
      if (len >= 28) begin
        body[28] = sum;
        img[28]  = sum;
      end else begin
        body[0] = body[0] + (img[28] - sum);
        img[0]  = body[0];
      end
    end
    gen_store = img;
    push_byte(sync_first);
    if (stray) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) begin
        push_byte(pick_other(sync_second, sync_second));
      end
    end
    push_byte(sync_second);
    push_byte(8'(len));
    for (int p = 0; p <= len; p++) push_byte(body[p]);
    push_byte(8'($urandom));
  endtask

  task automatic pick_length(output int len);
    int r;
    r = $urandom_range(99);
    if (r < 45) len = $urandom_range(0, 27);
    else if (r < 85) len = $urandom_range(28, 40);
    else len = $urandom_range(41, 80);
  endtask

  task automatic run_random(input int n);
    int start;
    int len;
    int r;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      r = $urandom_range(99);
      if (r < 10) begin
        push_noise($urandom_range(1, 4));
      end else if (r < 15 && sync_first != sync_second) begin
        push_byte(sync_first);
        push_byte(pick_other(sync_second, sync_second));
      end else begin
        pick_length(len);
        push_frame(len, $urandom_range(99) < 65, $urandom_range(99) < 20);
      end
    end
  endtask

  task automatic drain();
    while (rx_queue.size() > 0 || s_tvalid) @(posedge clk);
    while (awaited_fields.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ifr_pkg::CfgAddrW-1:0] addr,
                           input logic [7:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == ifr_pkg::CFG_FIRST_SYNC) sync_first = data;
    else if (addr == ifr_pkg::CFG_SECOND_SYNC) sync_second = data;
    else if (addr == ifr_pkg::CFG_SUM_SEED) seed_value = data;
  endtask

  task automatic set_config(input logic [7:0] a, input logic [7:0] b, input logic [7:0] s);
    write_reg(ifr_pkg::CFG_FIRST_SYNC, a);
    write_reg(ifr_pkg::CFG_SECOND_SYNC, b);
    write_reg(ifr_pkg::CFG_SUM_SEED, s);
  endtask

  initial begin
    for (int k = 0; k < ifr_pkg::StoreDepth; k++) begin
      rx_store[k]  = '0;
      gen_store[k] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_frame(0, 1'b0, 1'b0);
    push_noise(3);
    push_frame(0, 1'b1, 1'b1);
    push_frame(2, 1'b1, 1'b0);
    drain();

    set_config(8'h00, 8'hFF, 8'hFF);
    run_random(30);
    drain();

    steady = 1'b1;
    set_config(8'hFF, 8'h00, 8'h00);
    run_random(30);
    drain();
    steady = 1'b0;

    set_config(8'h5A, 8'h5A, 8'($urandom));
    run_random(30);
    drain();

    set_config(ifr_pkg::FirstSyncReset, ifr_pkg::SecondSyncReset, ifr_pkg::SumSeedReset);
    push_frame(255, 1'b1, 1'b0);
    push_frame(5, 1'b1, 1'b1);
    drain();

    if (fault_count == 0) begin
      $display("tb_imu_frame_receiver: clean");
    end else begin
      $display("tb_imu_frame_receiver: errors");
    end
    $finish;
  end

endmodule
